FILE: rtl/bcc_pkg.sv
// brew cycle controller shared types, register map and constants
package bcc_pkg;

	// controller modes
	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_HEATING = 2'd1;
	localparam logic [1:0] MODE_READY   = 2'd2;
	localparam logic [1:0] MODE_POURING = 2'd3;

	// register indexes, byte address is 4 * index
	localparam logic [1:0] REG_EVAL     = 2'd0;
	localparam logic [1:0] REG_BLINK    = 2'd1;
	localparam logic [1:0] REG_AUTO_OFF = 2'd2;
	localparam logic [1:0] REG_PWM      = 2'd3;

	localparam int ADDR_W = 4;

	// register reset values
	localparam logic [7:0]  EVAL_RESET     = 8'd10;
	localparam logic [15:0] BLINK_RESET    = 16'd500;
	localparam logic [19:0] AUTO_OFF_RESET = 20'd600000;
	localparam logic [14:0] PWM_RESET      = 15'd10000;

	// full-power duty step and reciprocal for the period split
	localparam int FULL_POWER = 100;
	localparam int RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [8:0] PWM_QUOT_RESET = 9'(int'(PWM_RESET) / FULL_POWER);

	typedef struct packed {
		logic button_level;
		logic capsule_present;
		logic hot_lever;
		logic cold_lever;
		logic boiler_hot;
	} tick_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        pump_on;
		logic        red_led;
		logic        green_led;
		logic [15:0] heater_compare;
	} res_t;

	// configuration as seen by the controller
	typedef struct packed {
		logic [7:0]  eval_period;
		logic [15:0] blink_period;
		logic [19:0] auto_off_period;
		logic [14:0] heat_period;
		logic [6:0]  pwm_rem;
	} cfg_t;

endpackage

FILE: rtl/brew_cycle_controller_unit.sv
// brew cycle controller top level: tick register, controller, result register
//
//  channel   direction  handshake                  payload
//  tick      in         tick_valid / tick_stall    tick (tick_t)
//  res       out        res_valid / res_stall      res (res_t)
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one tick per cycle sustained while res is not stalled; a taken tick waits in the tick
// register, and the controller steps it from there into the result register
// reset clears the mode, timers (to expired), LEDs, pump, heater and valid bits
// res_stall holds the result register; a tick waits in the tick register and
// tick_stall rises only when both registers are full and res is stalled
module brew_cycle_controller_unit import bcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	tick_t tick_s1;
	logic  valid_s1;
	logic  adv;
	logic  accept;
	res_t  result;
	res_t  res_q;
	logic  res_valid_q;

	bcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	// handshake
	assign adv        = valid_s1 && (!res_valid_q || !res_stall);
	assign tick_stall = valid_s1 && !adv;
	assign accept     = tick_valid && !tick_stall;

	// tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// idle always shows everything off
	a_idle_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.mode == MODE_IDLE |-> !res.pump_on && !res.red_led && !res.green_led)
		else $error("idle beat with an output still on");

	// pump runs exactly while pouring
	a_pump_pour: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.pump_on == (res.mode == MODE_POURING))
		else $error("pump drive disagrees with mode");

	// ready lights exactly one LED
	a_ready_led: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.mode == MODE_READY |-> res.green_led != res.red_led)
		else $error("ready beat with both or no LEDs lit");

	// a stall on the tick side only comes from a blocked result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> res_valid && res_stall && valid_s1)
		else $error("tick stalled without a blocked result");

endmodule

FILE: rtl/bcc_cfg.sv
// brew cycle controller configuration registers and heater period split
module bcc_cfg import bcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [7:0]  eval_q;
	logic [15:0] blink_q;
	logic [19:0] auto_off_q;
	logic [14:0] pwm_q;
	logic [8:0]  quot_q;
	logic [27:0] prod;
	logic [15:0] rem_full;
	logic        wr_en;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_q     <= EVAL_RESET;
			blink_q    <= BLINK_RESET;
			auto_off_q <= AUTO_OFF_RESET;
			pwm_q      <= PWM_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_EVAL:     eval_q     <= pwdata[7:0];
				REG_BLINK:    blink_q    <= pwdata[15:0];
				REG_AUTO_OFF: auto_off_q <= pwdata[19:0];
				REG_PWM:      pwm_q      <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_EVAL:     prdata = {24'd0, eval_q};
			REG_BLINK:    prdata = {16'd0, blink_q};
			REG_AUTO_OFF: prdata = {12'd0, auto_off_q};
			REG_PWM:      prdata = {17'd0, pwm_q};
			default:      prdata = 32'd0;
		endcase
	end

	// period / 100 by reciprocal, exact for every 15-bit period
	assign prod = 28'(pwm_q) * 28'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= PWM_QUOT_RESET;
		end else begin
			quot_q <= prod[RECIP_SHIFT +: 9];
		end
	end

	// remainder left over at full power
	assign rem_full = 16'(pwm_q) - 16'(quot_q) * 16'(FULL_POWER);

	assign cfg.eval_period     = eval_q;
	assign cfg.blink_period    = blink_q;
	assign cfg.auto_off_period = auto_off_q;
	assign cfg.heat_period     = pwm_q;
	assign cfg.pwm_rem         = rem_full[6:0];

endmodule

FILE: rtl/bcc_ctrl.sv
// brew cycle controller mode state, timers and next-state logic
module bcc_ctrl import bcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  tick_t tick,
	input  cfg_t  cfg,
	output res_t  result
);

	logic [1:0]  mode_q, nx_mode;
	logic        latch_q, nx_latch;
	logic [7:0]  eval_q, eval_inc, nx_eval;
	logic [15:0] blink_q, blink_inc, nx_blink;
	logic [19:0] auto_q, auto_inc, nx_auto;
	logic        red_q, nx_red;
	logic        green_q, nx_green;
	logic        pump_q, nx_pump;
	logic        full_q, nx_full;
	logic        valve;
	logic        press;

	// saturating tick counters
	assign eval_inc  = (eval_q == '1) ? eval_q : eval_q + 8'd1;
	assign blink_inc = (blink_q == '1) ? blink_q : blink_q + 16'd1;
	assign auto_inc  = (auto_q == '1) ? auto_q : auto_q + 20'd1;

	assign valve = tick.hot_lever | tick.cold_lever;
	assign press = tick.button_level && !latch_q;

	// one evaluation of the mode controller
	always_comb begin
		nx_mode  = mode_q;
		nx_latch = latch_q;
		nx_eval  = eval_inc;
		nx_blink = blink_inc;
		nx_auto  = auto_inc;
		nx_red   = red_q;
		nx_green = green_q;
		nx_pump  = pump_q;
		nx_full  = full_q;
		if (eval_inc >= cfg.eval_period) begin
			nx_eval = 8'd0;
			case (mode_q)
				MODE_IDLE: begin
					nx_latch = tick.button_level;
					if (press) begin
						nx_mode = MODE_HEATING;
						nx_full = 1'b1;
						nx_auto = 20'd0;
					end
				end
				MODE_HEATING: begin
					nx_latch = tick.button_level;
					if (press) begin
						nx_mode  = MODE_IDLE;
						nx_full  = 1'b0;
						nx_pump  = 1'b0;
						nx_red   = 1'b0;
						nx_green = 1'b0;
					end else if (blink_inc >= cfg.blink_period) begin
						if (tick.boiler_hot && tick.capsule_present && !valve) begin
							nx_mode  = MODE_READY;
							nx_green = 1'b1;
							nx_red   = 1'b0;
						end else begin
							nx_red   = tick.boiler_hot ? 1'b1 : !red_q;
							nx_blink = 16'd0;
						end
					end
				end
				MODE_READY: begin
					nx_latch = tick.button_level;
					if (press || auto_inc >= cfg.auto_off_period) begin
						nx_mode  = MODE_IDLE;
						nx_full  = 1'b0;
						nx_pump  = 1'b0;
						nx_red   = 1'b0;
						nx_green = 1'b0;
					end else if (!tick.boiler_hot) begin
						nx_mode  = MODE_HEATING;
						nx_green = 1'b0;
						nx_red   = 1'b1;
					end else if (!tick.capsule_present) begin
						nx_green = 1'b0;
						nx_red   = 1'b1;
					end else if (valve) begin
						nx_mode  = MODE_POURING;
						nx_pump  = 1'b1;
						nx_green = 1'b0;
						nx_red   = 1'b1;
					end else begin
						nx_green = 1'b1;
						nx_red   = 1'b0;
					end
				end
				default: begin
					// pouring: button not sampled, latch holds
					if (!valve) begin
						nx_mode  = MODE_READY;
						nx_pump  = 1'b0;
						nx_red   = 1'b0;
						nx_green = 1'b1;
					end
				end
			endcase
		end
	end

	// state registers, timers start expired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			latch_q <= 1'b0;
			eval_q  <= '1;
			blink_q <= '1;
			auto_q  <= '1;
			red_q   <= 1'b0;
			green_q <= 1'b0;
			pump_q  <= 1'b0;
			full_q  <= 1'b0;
		end else if (step) begin
			mode_q  <= nx_mode;
			latch_q <= nx_latch;
			eval_q  <= nx_eval;
			blink_q <= nx_blink;
			auto_q  <= nx_auto;
			red_q   <= nx_red;
			green_q <= nx_green;
			pump_q  <= nx_pump;
			full_q  <= nx_full;
		end
	end

	// result shows the state after this tick
	assign result.mode           = nx_mode;
	assign result.pump_on        = nx_pump;
	assign result.red_led        = nx_red;
	assign result.green_led      = nx_green;
	assign result.heater_compare = nx_full ? {9'd0, cfg.pwm_rem} : {cfg.heat_period, 1'b0};

endmodule
